// ===== rtl/sitc_pkg.sv =====
// Shared types, codes and reset values for the study interval timer.
// Used by the register block, the classifier and the timer core.
package sitc_pkg;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_FOCUS  = 3'd0;
	localparam logic [2:0] REG_SHORT  = 3'd1;
	localparam logic [2:0] REG_LONG   = 3'd2;
	localparam logic [2:0] REG_COLD   = 3'd3;
	localparam logic [2:0] REG_HOT    = 3'd4;
	localparam logic [2:0] REG_DRY    = 3'd5;
	localparam logic [2:0] REG_HUMID  = 3'd6;
	localparam logic [2:0] REG_PERIOD = 3'd7;

	// Register reset values.
	localparam logic [15:0] FOCUS_RESET  = 16'd1500;
	localparam logic [15:0] SHORT_RESET  = 16'd300;
	localparam logic [15:0] LONG_RESET   = 16'd900;
	localparam logic [11:0] COLD_RESET   = 12'd180;
	localparam logic [11:0] HOT_RESET    = 12'd280;
	localparam logic [9:0]  DRY_RESET    = 10'd300;
	localparam logic [9:0]  HUMID_RESET  = 10'd700;
	localparam logic [7:0]  PERIOD_RESET = 8'd5;

	// Event codes.
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_MODE  = 3'd1;
	localparam logic [2:0] OP_RESET = 3'd2;
	localparam logic [2:0] OP_MUTE  = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	// Interval modes.
	localparam logic [1:0] MODE_STUDY = 2'd0;
	localparam logic [1:0] MODE_SHORT = 2'd1;
	localparam logic [1:0] MODE_LONG  = 2'd2;

	// Comfort classes.
	localparam logic [2:0] CF_ERROR = 3'd0;
	localparam logic [2:0] CF_OK    = 3'd1;
	localparam logic [2:0] CF_COLD  = 3'd2;
	localparam logic [2:0] CF_HOT   = 3'd3;
	localparam logic [2:0] CF_DRY   = 3'd4;
	localparam logic [2:0] CF_HUMID = 3'd5;

	// Buzzer commands.
	localparam logic [1:0] BZ_NONE  = 2'd0;
	localparam logic [1:0] BZ_STOP  = 2'd1;
	localparam logic [1:0] BZ_THREE = 2'd2;
	localparam logic [1:0] BZ_ONE   = 2'd3;

	typedef struct packed {
		logic [15:0]        focus_length;
		logic [15:0]        short_break_length;
		logic [15:0]        long_break_length;
		logic signed [11:0] cold_limit;
		logic signed [11:0] hot_limit;
		logic [9:0]         dry_limit;
		logic [9:0]         humid_limit;
		logic [7:0]         sample_period;
	} cfg_t;

endpackage

// ===== rtl/study_interval_timer_with_comfort_check_top.sv =====
// Channel   Dir  Width         Contents
// s_*       in   tdata 24      event operands; tuser 4 carries opcode and sample_ok
// m_*       out  tdata 32      timer status and buzzer command for each event
// APB       in   addr 5/data 32  eight configuration registers at 4*index
//
// One event is accepted in every cycle unless the result channel stalls; its result passes
// the input register, then the event logic, then the result register, and is offered there.
// Reset loads the default lengths and limits and leaves the timer idle in focus mode.
// A stalled result holds in the result register while one more event waits in the
// input register; s_tready falls only when both are full.
// Depends on sitc_pkg, sitc_cfg_regs, sitc_classify and sitc_core.
module study_interval_timer_with_comfort_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // temperature[11:0], humidity[21:12], zero[23:22]
	input  logic [3:0]  s_tuser,   // opcode[2:0], sample_ok[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // run_state[1:0], interval_mode[3:2], seconds_left[19:4],
	                               // comfort[22:20], sound_muted[23], buzzer_command[25:24],
	                               // zero[31:26]
);

	sitc_pkg::cfg_t cfg;
	logic [1:0]     run_state;
	logic [1:0]     interval_mode;
	logic [15:0]    seconds_left;
	logic [2:0]     comfort;
	logic           sound_muted;
	logic [1:0]     buzzer_command;

	sitc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sitc_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.in_opcode          (s_tuser[2:0]),
		.in_sample_ok       (s_tuser[3]),
		.in_temperature     (s_tdata[11:0]),
		.in_humidity        (s_tdata[21:12]),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_run_state      (run_state),
		.out_interval_mode  (interval_mode),
		.out_seconds_left   (seconds_left),
		.out_comfort        (comfort),
		.out_sound_muted    (sound_muted),
		.out_buzzer_command (buzzer_command)
	);

	assign m_tdata = {6'd0, buzzer_command, sound_muted, comfort, seconds_left,
	                  interval_mode, run_state};

endmodule

// ===== rtl/sitc_cfg_regs.sv =====
// Configuration register bank behind an APB-style port.
// Depends on sitc_pkg for register indexes, reset values and cfg_t.
module sitc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output sitc_pkg::cfg_t     cfg
);

	sitc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus_length       <= sitc_pkg::FOCUS_RESET;
			cfg_q.short_break_length <= sitc_pkg::SHORT_RESET;
			cfg_q.long_break_length  <= sitc_pkg::LONG_RESET;
			cfg_q.cold_limit         <= sitc_pkg::COLD_RESET;
			cfg_q.hot_limit          <= sitc_pkg::HOT_RESET;
			cfg_q.dry_limit          <= sitc_pkg::DRY_RESET;
			cfg_q.humid_limit        <= sitc_pkg::HUMID_RESET;
			cfg_q.sample_period      <= sitc_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			unique case (idx)
				sitc_pkg::REG_FOCUS:  cfg_q.focus_length       <= pwdata[15:0];
				sitc_pkg::REG_SHORT:  cfg_q.short_break_length <= pwdata[15:0];
				sitc_pkg::REG_LONG:   cfg_q.long_break_length  <= pwdata[15:0];
				sitc_pkg::REG_COLD:   cfg_q.cold_limit         <= pwdata[11:0];
				sitc_pkg::REG_HOT:    cfg_q.hot_limit          <= pwdata[11:0];
				sitc_pkg::REG_DRY:    cfg_q.dry_limit          <= pwdata[9:0];
				sitc_pkg::REG_HUMID:  cfg_q.humid_limit        <= pwdata[9:0];
				sitc_pkg::REG_PERIOD: cfg_q.sample_period      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sitc_pkg::REG_FOCUS:  prdata = {16'd0, cfg_q.focus_length};
			sitc_pkg::REG_SHORT:  prdata = {16'd0, cfg_q.short_break_length};
			sitc_pkg::REG_LONG:   prdata = {16'd0, cfg_q.long_break_length};
			sitc_pkg::REG_COLD:   prdata = {20'd0, cfg_q.cold_limit};
			sitc_pkg::REG_HOT:    prdata = {20'd0, cfg_q.hot_limit};
			sitc_pkg::REG_DRY:    prdata = {22'd0, cfg_q.dry_limit};
			sitc_pkg::REG_HUMID:  prdata = {22'd0, cfg_q.humid_limit};
			sitc_pkg::REG_PERIOD: prdata = {24'd0, cfg_q.sample_period};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/sitc_classify.sv =====
// Comfort classifier: sorts one sensor sample against the limit registers.
// Depends on sitc_pkg for the comfort codes and cfg_t.
module sitc_classify (
	input  logic               sample_ok,
	input  logic signed [11:0] temperature,
	input  logic [9:0]         humidity,
	input  sitc_pkg::cfg_t     cfg,
	output logic [2:0]         comfort
);

	// Checks are in priority order: temperature faults mask humidity faults.
	always_comb begin
		if (!sample_ok) begin
			comfort = sitc_pkg::CF_ERROR;
		end else if (temperature < $signed(cfg.cold_limit)) begin
			comfort = sitc_pkg::CF_COLD;
		end else if (temperature > $signed(cfg.hot_limit)) begin
			comfort = sitc_pkg::CF_HOT;
		end else if (humidity < cfg.dry_limit) begin
			comfort = sitc_pkg::CF_DRY;
		end else if (humidity > cfg.humid_limit) begin
			comfort = sitc_pkg::CF_HUMID;
		end else begin
			comfort = sitc_pkg::CF_OK;
		end
	end

endmodule

// ===== rtl/sitc_core.sv =====
// Timer core: input register, event logic with the timer state, result register.
// Depends on sitc_pkg and instantiates sitc_classify.
module sitc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sitc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         in_opcode,
	input  logic               in_sample_ok,
	input  logic signed [11:0] in_temperature,
	input  logic [9:0]         in_humidity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_run_state,
	output logic [1:0]         out_interval_mode,
	output logic [15:0]        out_seconds_left,
	output logic [2:0]         out_comfort,
	output logic               out_sound_muted,
	output logic [1:0]         out_buzzer_command
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RUN   = 2'd1,
		PH_PAUSE = 2'd2,
		PH_ALARM = 2'd3
	} phase_t;

	// Input register.
	logic               valid_s1;
	logic [2:0]         op_s1;
	logic               ok_s1;
	logic signed [11:0] temp_s1;
	logic [9:0]         hum_s1;

	// Result register.
	logic               valid_s2;
	phase_t             phase_s2;
	logic [1:0]         mode_s2;
	logic [15:0]        secs_s2;
	logic [2:0]         comfort_s2;
	logic               muted_s2;
	logic [1:0]         cmd_s2;

	// Timer state.
	phase_t      phase_q;
	logic [1:0]  mode_q;
	logic [15:0] cd_q;
	logic [2:0]  comfort_q;
	logic [7:0]  div_q;
	logic        muted_q;

	phase_t      phase_d;
	logic [1:0]  mode_d;
	logic [15:0] cd_d;
	logic [2:0]  comfort_d;
	logic [7:0]  div_d;
	logic        muted_d;
	logic [1:0]  cmd_d;

	logic        s2_ready;
	logic        adv;
	logic [2:0]  sample_class;
	logic [15:0] cd_dec;
	logic [7:0]  div_inc;
	logic [1:0]  mode_next;

	assign s2_ready = !valid_s2 || out_ready;
	assign adv      = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	function automatic logic [15:0] len_of(input logic [1:0] m, input sitc_pkg::cfg_t c);
		logic [15:0] len;
		case (m)
			sitc_pkg::MODE_SHORT: len = c.short_break_length;
			sitc_pkg::MODE_LONG:  len = c.long_break_length;
			default:              len = c.focus_length;
		endcase
		return len;
	endfunction

	sitc_classify u_classify (
		.sample_ok   (ok_s1),
		.temperature (temp_s1),
		.humidity    (hum_s1),
		.cfg         (cfg),
		.comfort     (sample_class)
	);

	assign cd_dec  = (cd_q != 16'd0) ? cd_q - 16'd1 : 16'd0;
	assign div_inc = div_q + 8'd1;

	// Long break wraps to focus; the unused mode code falls through to short break.
	always_comb begin
		case (mode_q)
			sitc_pkg::MODE_SHORT: mode_next = sitc_pkg::MODE_LONG;
			sitc_pkg::MODE_LONG:  mode_next = sitc_pkg::MODE_STUDY;
			default:              mode_next = sitc_pkg::MODE_SHORT;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		mode_d    = mode_q;
		cd_d      = cd_q;
		comfort_d = comfort_q;
		div_d     = div_q;
		muted_d   = muted_q;
		cmd_d     = sitc_pkg::BZ_NONE;
		case (op_s1)
			sitc_pkg::OP_START: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (cd_q == 16'd0) begin
							cd_d = len_of(mode_q, cfg);
						end
						phase_d = PH_RUN;
					end
					PH_RUN:   phase_d = PH_PAUSE;
					PH_PAUSE: phase_d = PH_RUN;
					PH_ALARM: begin
						phase_d = PH_IDLE;
						cd_d    = len_of(mode_q, cfg);
						cmd_d   = sitc_pkg::BZ_STOP;
					end
					default: ;
				endcase
			end
			sitc_pkg::OP_MODE: begin
				if (phase_q == PH_IDLE) begin
					mode_d = mode_next;
					cd_d   = len_of(mode_next, cfg);
				end
			end
			sitc_pkg::OP_RESET: begin
				phase_d = PH_IDLE;
				cd_d    = len_of(mode_q, cfg);
				cmd_d   = sitc_pkg::BZ_STOP;
			end
			sitc_pkg::OP_MUTE: muted_d = !muted_q;
			sitc_pkg::OP_TICK: begin
				if (phase_q == PH_RUN) begin
					cd_d = cd_dec;
					if (cd_dec == 16'd0) begin
						phase_d = PH_ALARM;
						cmd_d   = sitc_pkg::BZ_THREE;
					end
				end
				div_d = div_inc;
				if (div_inc >= cfg.sample_period) begin
					div_d     = 8'd0;
					comfort_d = sample_class;
					// A new fault after a good reading beeps once, but never over the alarm.
					if (comfort_q == sitc_pkg::CF_OK && sample_class != sitc_pkg::CF_OK &&
					    sample_class != sitc_pkg::CF_ERROR && phase_d != PH_ALARM) begin
						cmd_d = sitc_pkg::BZ_ONE;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= in_opcode;
			ok_s1   <= in_sample_ok;
			temp_s1 <= in_temperature;
			hum_s1  <= in_humidity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			mode_q    <= sitc_pkg::MODE_STUDY;
			cd_q      <= sitc_pkg::FOCUS_RESET;
			comfort_q <= sitc_pkg::CF_ERROR;
			div_q     <= sitc_pkg::PERIOD_RESET - 8'd1;
			muted_q   <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (adv) begin
				phase_q   <= phase_d;
				mode_q    <= mode_d;
				cd_q      <= cd_d;
				comfort_q <= comfort_d;
				div_q     <= div_d;
				muted_q   <= muted_d;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2   <= phase_d;
			mode_s2    <= mode_d;
			secs_s2    <= cd_d;
			comfort_s2 <= comfort_d;
			muted_s2   <= muted_d;
			cmd_s2     <= cmd_d;
		end
	end

	assign out_valid          = valid_s2;
	assign out_run_state      = phase_s2;
	assign out_interval_mode  = mode_s2;
	assign out_seconds_left   = secs_s2;
	assign out_comfort        = comfort_s2;
	assign out_sound_muted    = muted_s2;
	assign out_buzzer_command = cmd_s2;

	a_three_beeps_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cmd_s2 == sitc_pkg::BZ_THREE |-> phase_s2 == PH_ALARM)
		else $error("three-beep command shown without the alarm state");

	a_stop_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cmd_s2 == sitc_pkg::BZ_STOP |-> phase_s2 == PH_IDLE)
		else $error("stop command shown outside the idle state");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(mode_q) && $stable(cd_q) && $stable(muted_q))
		else $error("timer state changed without a transfer into the result register");

	a_comfort_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && op_s1 == sitc_pkg::OP_TICK) |=> $stable(comfort_q) && $stable(div_q))
		else $error("comfort class or divider changed on a non-tick event");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> phase_s2 == phase_q && secs_s2 == cd_q && comfort_s2 == comfort_q)
		else $error("result register disagrees with the timer state");

endmodule
